// ----- rtl/pif_pkg.sv -----
package pif_pkg;

   localparam int DEF_MAX_WIDTH = 64;
   localparam int DEF_SPEC_MAX  = 62;
   localparam int DIGIT_COUNT   = 20;
   localparam int WIDTH_W       = 7;
   localparam int BCD_W         = 4 * DIGIT_COUNT;
   localparam int DIDX_W        = $clog2(DIGIT_COUNT);

   // parser phases
   localparam logic [2:0] PH_TEXT  = 3'd0;
   localparam logic [2:0] PH_FLAGS = 3'd1;
   localparam logic [2:0] PH_WIDTH = 3'd2;
   localparam logic [2:0] PH_L1    = 3'd3;
   localparam logic [2:0] PH_L2    = 3'd4;

   // flag bits
   localparam int F_PLUS  = 0;
   localparam int F_MINUS = 1;
   localparam int F_SPACE = 2;
   localparam int F_ZERO  = 3;
   localparam int F_LL    = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_I     = 8'h69;

   typedef struct packed {
      logic [7:0]  fmt_char;
      logic [63:0] arg_value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/pif_ram.sv -----
module pif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 62
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/printf_integer_formatter.sv -----
// Streaming printf-style integer formatter.
// req_ channel: one format byte per word, with the argument that a u/d/i
// conversion ending on that byte consumes. rsp_ channel: output text bytes,
// last marks the final byte caused by one request word (a word may cause
// none). A NUL request byte ends the string and produces a NUL response.
// req_stall is high while the sequencer works on a word; one word at a time.
// Per word: a plain byte is echoed and a flag byte is stored; a raw
// specifier echo reads each kept byte back through the registered read of
// the specifier RAM; a conversion runs 32 (or 64 for ll) double-dabble
// steps of the shared BCD shift/add-3 unit, a leading-zero scan, the pad
// calculation, then one output character per cycle while the output is not stalled.
// Results leave through a one-word output register; while rsp_stall is high
// and that register is full, it holds and the sequencer waits to emit.
// Reset returns the parser to plain text and empties the output register;
// the specifier RAM needs no clearing.
module printf_integer_formatter #(
   parameter int MAX_WIDTH = pif_pkg::DEF_MAX_WIDTH,
   parameter int SPEC_MAX  = pif_pkg::DEF_SPEC_MAX
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pif_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pif_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(SPEC_MAX);
   localparam int CW = $clog2(SPEC_MAX + 1);
   localparam int WW = pif_pkg::WIDTH_W;
   localparam int BW = pif_pkg::BCD_W;
   localparam int DW = pif_pkg::DIDX_W;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_EMIT1 = 12'b0000_0000_0010,
      ST_FL_RD = 12'b0000_0000_0100,
      ST_FL_WR = 12'b0000_0000_1000,
      ST_DAB   = 12'b0000_0001_0000,
      ST_SCAN  = 12'b0000_0010_0000,
      ST_PAD   = 12'b0000_0100_0000,
      ST_PRE   = 12'b0000_1000_0000,
      ST_SIGN  = 12'b0001_0000_0000,
      ST_ZER   = 12'b0010_0000_0000,
      ST_DIG   = 12'b0100_0000_0000,
      ST_POST  = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         phase_ff, phase_in;
   logic [4:0]         flags_ff, flags_in;
   logic [WW-1:0]      width_ff, width_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      fi_ff, fi_in;
   logic               tail_en_ff, tail_en_in;
   logic               tail_start_ff, tail_start_in;
   logic [7:0]         tail_char_ff, tail_char_in;
   logic [7:0]         char_ff, char_in;
   logic [63:0]        v_ff, v_in;
   logic [BW-1:0]      bcd_ff, bcd_in;
   logic [6:0]         it_ff, it_in;
   logic [DW-1:0]      didx_ff, didx_in;
   logic               sgn_ff, sgn_in;
   logic [7:0]         sign_ff, sign_in;
   logic [6:0]         pc_ff, pc_in;
   logic [6:0]         rem_ff, rem_in;
   logic               rsp_valid_ff;
   pif_pkg::rsp_type   rsp_ff;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_wa;
   logic [7:0]         ram_wd, ram_rd;

   logic               can_emit, emit_en, emit_last;
   logic [7:0]         emit_char;
   logic               do_keep, do_start;

   logic [7:0]         c;
   logic               is_flag, is_num, is_conv;
   logic [9:0]         wmul;
   logic [BW-1:0]      adj;
   logic [3:0]         cur_digit;
   logic [4:0]         flag_bit;
   logic               wide, neg;
   logic [31:0]        lo_mag;
   logic [63:0]        mag;
   logic [DW:0]        len;
   logic signed [8:0]  pad;
   logic [6:0]         padpos;
   logic               fl_end;

   pif_ram #(
      .WIDTH (8),
      .DEPTH (SPEC_MAX)
   ) u_spec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (fi_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   assign c        = req_data.fmt_char;
   assign is_flag  = (c == pif_pkg::CH_PLUS) || (c == pif_pkg::CH_MINUS) ||
                     (c == pif_pkg::CH_ZERO) || (c == pif_pkg::CH_SPACE);
   assign is_num   = (c >= pif_pkg::CH_ZERO) && (c <= pif_pkg::CH_NINE);
   assign is_conv  = (c == pif_pkg::CH_U) || (c == pif_pkg::CH_D) || (c == pif_pkg::CH_I);
   assign wmul     = 10'(width_ff) * 10'd10 + 10'(c[3:0]);
   assign flag_bit = (c == pif_pkg::CH_PLUS)  ? 5'(1 << pif_pkg::F_PLUS)  :
                     (c == pif_pkg::CH_MINUS) ? 5'(1 << pif_pkg::F_MINUS) :
                     (c == pif_pkg::CH_ZERO)  ? 5'(1 << pif_pkg::F_ZERO)  :
                                                5'(1 << pif_pkg::F_SPACE);

   // sign handling and magnitude of the argument
   assign wide   = flags_ff[pif_pkg::F_LL];
   assign neg    = (c != pif_pkg::CH_U) &&
                   (wide ? req_data.arg_value[63] : req_data.arg_value[31]);
   assign lo_mag = neg ? (~req_data.arg_value[31:0] + 32'd1) : req_data.arg_value[31:0];
   assign mag    = wide ? (neg ? (~req_data.arg_value + 64'd1) : req_data.arg_value)
                        : {lo_mag, 32'd0};

   // add-3 correction on every BCD digit
   always_comb begin
      for (int k = 0; k < pif_pkg::DIGIT_COUNT; k++) begin
         adj[4*k +: 4] = (bcd_ff[4*k +: 4] >= 4'd5) ? bcd_ff[4*k +: 4] + 4'd3
                                                     : bcd_ff[4*k +: 4];
      end
   end

   assign cur_digit = bcd_ff[{didx_ff, 2'b00} +: 4];
   assign len       = (DW+1)'(didx_ff) + 1'b1;
   assign pad       = 9'(width_ff) - 9'(len) - 9'(sgn_ff);
   assign padpos    = (pad > 0) ? pad[6:0] : 7'd0;
   assign fl_end    = (fi_ff == count_ff - 1'b1);
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      flags_in      = flags_ff;
      width_in      = width_ff;
      count_in      = count_ff;
      fi_in         = fi_ff;
      tail_en_in    = tail_en_ff;
      tail_start_in = tail_start_ff;
      tail_char_in  = tail_char_ff;
      char_in       = char_ff;
      v_in          = v_ff;
      bcd_in        = bcd_ff;
      it_in         = it_ff;
      didx_in       = didx_ff;
      sgn_in        = sgn_ff;
      sign_in       = sign_ff;
      pc_in         = pc_ff;
      rem_in        = rem_ff;
      ram_re        = 1'b0;
      emit_en       = 1'b0;
      emit_char     = pif_pkg::CH_NUL;
      emit_last     = 1'b0;
      do_keep       = 1'b0;
      do_start      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (phase_ff == pif_pkg::PH_FLAGS || phase_ff == pif_pkg::PH_WIDTH) begin
                  if (c == pif_pkg::CH_NUL) begin
                     state_in     = ST_FL_RD;
                     fi_in        = '0;
                     tail_en_in   = 1'b1;
                     tail_start_in = 1'b0;
                     tail_char_in = pif_pkg::CH_NUL;
                  end else if (phase_ff == pif_pkg::PH_FLAGS && is_flag) begin
                     flags_in = flags_ff | flag_bit;
                     do_keep  = 1'b1;
                  end else if (is_num) begin
                     width_in = (wmul > 10'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : wmul[WW-1:0];
                     do_keep  = 1'b1;
                     phase_in = pif_pkg::PH_WIDTH;
                  end else if (c == pif_pkg::CH_PCT) begin
                     char_in  = pif_pkg::CH_PCT;
                     state_in = ST_EMIT1;
                     count_in = '0;
                     phase_in = pif_pkg::PH_TEXT;
                  end else if (c == pif_pkg::CH_L) begin
                     do_keep  = 1'b1;
                     phase_in = pif_pkg::PH_L1;
                  end else if (is_conv) begin
                     state_in = ST_DAB;
                  end else begin
                     do_keep       = 1'b1;
                     state_in      = ST_FL_RD;
                     fi_in         = '0;
                     tail_en_in    = 1'b0;
                     tail_start_in = 1'b0;
                  end
               end else if (phase_ff == pif_pkg::PH_L1) begin
                  if (c == pif_pkg::CH_L) begin
                     do_keep  = 1'b1;
                     flags_in = flags_ff | 5'(1 << pif_pkg::F_LL);
                     phase_in = pif_pkg::PH_L2;
                  end else begin
                     // echo the text, then treat this byte as plain text
                     state_in      = ST_FL_RD;
                     fi_in         = '0;
                     tail_start_in = (c == pif_pkg::CH_PCT);
                     tail_en_in    = (c != pif_pkg::CH_PCT);
                     tail_char_in  = c;
                  end
               end else if (phase_ff == pif_pkg::PH_L2) begin
                  if (c == pif_pkg::CH_NUL) begin
                     state_in      = ST_FL_RD;
                     fi_in         = '0;
                     tail_en_in    = 1'b1;
                     tail_start_in = 1'b0;
                     tail_char_in  = pif_pkg::CH_NUL;
                  end else if (is_conv) begin
                     state_in = ST_DAB;
                  end else begin
                     do_keep       = 1'b1;
                     state_in      = ST_FL_RD;
                     fi_in         = '0;
                     tail_en_in    = 1'b0;
                     tail_start_in = 1'b0;
                  end
               end else begin
                  phase_in = pif_pkg::PH_TEXT;
                  if (c == pif_pkg::CH_PCT) begin
                     do_start = 1'b1;
                  end else begin
                     char_in  = c;
                     state_in = ST_EMIT1;
                  end
               end

               // launch a conversion: load the shift unit
               if (state_in == ST_DAB) begin
                  v_in     = mag;
                  bcd_in   = '0;
                  it_in    = wide ? 7'd64 : 7'd32;
                  count_in = '0;
                  phase_in = pif_pkg::PH_TEXT;
                  sgn_in   = neg || flags_ff[pif_pkg::F_PLUS] || flags_ff[pif_pkg::F_SPACE];
                  sign_in  = neg ? pif_pkg::CH_MINUS :
                             flags_ff[pif_pkg::F_PLUS] ? pif_pkg::CH_PLUS : pif_pkg::CH_SPACE;
               end
            end
         end

         ST_EMIT1: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = char_ff;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         ST_FL_RD: begin
            ram_re   = 1'b1;
            state_in = ST_FL_WR;
         end

         ST_FL_WR: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = ram_rd;
               emit_last = fl_end && !tail_en_ff;
               if (fl_end) begin
                  count_in = '0;
                  phase_in = pif_pkg::PH_TEXT;
                  do_start = tail_start_ff;
                  char_in  = tail_char_ff;
                  state_in = tail_en_ff ? ST_EMIT1 : ST_IDLE;
               end else begin
                  fi_in    = fi_ff + 1'b1;
                  state_in = ST_FL_RD;
               end
            end
         end

         ST_DAB: begin
            bcd_in = {adj[BW-2:0], v_ff[63]};
            v_in   = {v_ff[62:0], 1'b0};
            it_in  = it_ff - 1'b1;
            if (it_ff == 7'd1) begin
               didx_in  = DW'(pif_pkg::DIGIT_COUNT - 1);
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // drop leading zeros, keep at least one digit
            if (didx_ff != '0 && cur_digit == 4'd0) begin
               didx_in = didx_ff - 1'b1;
            end else begin
               state_in = ST_PAD;
            end
         end

         ST_PAD: begin
            pc_in  = padpos;
            rem_in = 7'(len) + 7'(sgn_ff) + padpos;
            if (padpos != 7'd0 && !flags_ff[pif_pkg::F_MINUS] && !flags_ff[pif_pkg::F_ZERO]) begin
               state_in = ST_PRE;
            end else if (sgn_ff) begin
               state_in = ST_SIGN;
            end else if (padpos != 7'd0 && !flags_ff[pif_pkg::F_MINUS]) begin
               state_in = ST_ZER;
            end else begin
               state_in = ST_DIG;
            end
         end

         ST_PRE: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = pif_pkg::CH_SPACE;
               emit_last = (rem_ff == 7'd1);
               rem_in    = rem_ff - 1'b1;
               pc_in     = pc_ff - 1'b1;
               if (pc_ff == 7'd1) begin
                  state_in = sgn_ff ? ST_SIGN : ST_DIG;
               end
            end
         end

         ST_SIGN: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = sign_ff;
               emit_last = (rem_ff == 7'd1);
               rem_in    = rem_ff - 1'b1;
               state_in  = (pc_ff != 7'd0 && !flags_ff[pif_pkg::F_MINUS]) ? ST_ZER : ST_DIG;
            end
         end

         ST_ZER: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = pif_pkg::CH_ZERO;
               emit_last = (rem_ff == 7'd1);
               rem_in    = rem_ff - 1'b1;
               pc_in     = pc_ff - 1'b1;
               if (pc_ff == 7'd1) begin
                  state_in = ST_DIG;
               end
            end
         end

         ST_DIG: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = pif_pkg::CH_ZERO | {4'd0, cur_digit};
               emit_last = (rem_ff == 7'd1);
               rem_in    = rem_ff - 1'b1;
               if (didx_ff == '0) begin
                  state_in = (pc_ff != 7'd0) ? ST_POST : ST_IDLE;
               end else begin
                  didx_in = didx_ff - 1'b1;
               end
            end
         end

         ST_POST: begin
            if (can_emit) begin
               emit_en   = 1'b1;
               emit_char = pif_pkg::CH_SPACE;
               emit_last = (rem_ff == 7'd1);
               rem_in    = rem_ff - 1'b1;
               pc_in     = pc_ff - 1'b1;
               if (pc_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // specifier RAM write port: keep a byte, or open a new specifier
      ram_we = 1'b0;
      ram_wa = '0;
      ram_wd = c;
      if (do_start) begin
         ram_we   = 1'b1;
         ram_wd   = pif_pkg::CH_PCT;
         count_in = CW'(1);
         phase_in = pif_pkg::PH_FLAGS;
         flags_in = '0;
         width_in = '0;
      end else if (do_keep && count_ff < CW'(SPEC_MAX)) begin
         ram_we   = 1'b1;
         ram_wa   = count_ff[AW-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= pif_pkg::PH_TEXT;
         flags_ff     <= '0;
         width_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         width_ff <= width_in;
         count_ff <= count_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      fi_ff         <= fi_in;
      tail_en_ff    <= tail_en_in;
      tail_start_ff <= tail_start_in;
      tail_char_ff  <= tail_char_in;
      char_ff       <= char_in;
      v_ff          <= v_in;
      bcd_ff        <= bcd_in;
      it_ff         <= it_in;
      didx_ff       <= didx_in;
      sgn_ff        <= sgn_in;
      sign_ff       <= sign_in;
      pc_ff         <= pc_in;
      rem_ff        <= rem_in;
      if (emit_en) begin
         rsp_ff.out_char <= emit_char;
         rsp_ff.last     <= emit_last;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
